// ----- rtl/rectangle_outline_drawer_macros.svh -----
// Assertion helpers for the RTL top level.
`ifndef RECTANGLE_OUTLINE_DRAWER_MACROS_SVH
`define RECTANGLE_OUTLINE_DRAWER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ROD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ROD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rod_pkg.sv -----
`timescale 1ns / 1ps
package rod_pkg;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 128;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_IW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_IW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CFG_W    = 8;
    localparam int PIX_W    = 8;
    localparam int CRD_W    = 18;

    localparam logic signed [CRD_W-1:0] CRD_ONE  = 1;
    localparam logic signed [CRD_W-1:0] CRD_ZERO = 0;

    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    typedef struct packed {
        logic [1:0]        func;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
        logic [PIX_W-1:0]  pixel_color;
    } t_cmd;

    typedef struct packed {
        logic [PIX_W-1:0] read_value;
        logic             outside_frame;
    } t_res;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
    } t_mem_req;

    typedef struct packed {
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;
    } t_frame;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_CLIP,
        ST_ROW,
        ST_SPAN,
        ST_RIGHT,
        ST_PIX,
        ST_RWAIT,
        ST_DONE
    } t_state;

    function automatic logic signed [CRD_W-1:0] sx16(logic signed [15:0] v);
        return {{(CRD_W-16){v[15]}}, v};
    endfunction

    function automatic logic signed [CRD_W-1:0] ux8(logic [CFG_W-1:0] v);
        return {{(CRD_W-CFG_W){1'b0}}, v};
    endfunction

endpackage

// ----- rtl/rectangle_outline_drawer.sv -----
// Steps to the o_done beat: pixel write PIX, DONE; pixel read PIX, RWAIT, DONE; outside
//   access PIX, DONE; spare code DONE; zero-size draw SETUP, DONE. Draw: SETUP, CLIP,
//   each clipped row (edge: ROW, SPAN per further column; interior: ROW, RIGHT), ROW, DONE.
// Throughput: one command at a time; busy stays high until the o_done beat and
//   the next accept can come in the cycle after it.
// Reset (synchronous, active low) clears the frame in a pass over every address.
`timescale 1ns / 1ps
`include "rectangle_outline_drawer_macros.svh"
module rectangle_outline_drawer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  rod_pkg::t_cmd             i_cmd,
    output logic                      o_done,
    output rod_pkg::t_res             o_result,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [rod_pkg::CFG_W-1:0] i_cfg_wdata
);
    import rod_pkg::*;

    // Frame size registers; the user must write them only while the block is idle (not enforced here).
    logic [CFG_W-1:0] r_frame_cols;
    logic [CFG_W-1:0] r_frame_rows;
    t_frame           frame_eff;
    t_mem_req         mem_req;
    logic [PIX_W-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cols <= CFG_RESET;
            r_frame_rows <= CFG_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_COLS) begin
                r_frame_cols <= i_cfg_wdata;
            end
            if (i_cfg_idx == CFG_ROWS) begin
                r_frame_rows <= i_cfg_wdata;
            end
        end
    end

    // Clamp the frame size to the store geometry.
    always_comb begin
        frame_eff.cols = ({3'b000, r_frame_cols} > 11'(MAX_COLS))
                       ? CFG_W'(MAX_COLS) : r_frame_cols;
        frame_eff.rows = ({3'b000, r_frame_rows} > 11'(MAX_ROWS))
                       ? CFG_W'(MAX_ROWS) : r_frame_rows;
    end

    // Command sequencer: clear pass, pixel access and outline walk.
    rod_raster u_raster (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_frame (frame_eff),
        .i_rdata (mem_rdata),
        .o_mem   (mem_req),
        .o_res   (o_result),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Framebuffer: one port, one pixel per cycle, registered read.
    rod_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_re    (mem_req.re),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (mem_rdata)
    );

    // An accepted command always holds busy in the next cycle.
    `ROD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")
    // The result beat ends the command.
    `ROD_ASSERT_NEXT(a_done_idle, o_done, !busy && !o_done, "no return to idle after beat")
    // No write or read reaches the store while idle.
    `ROD_ASSERT_SAME(a_idle_quiet, !busy, !mem_req.we && !mem_req.re, "memory access while idle")
    // An outside access reports a zero pixel value.
    `ROD_ASSERT_SAME(a_outside_zero, o_done && o_result.outside_frame,
        o_result.read_value == '0, "outside access returned data")

endmodule

// ----- rtl/rod_ram.sv -----
`timescale 1ns / 1ps
module rod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rod_raster.sv -----
`timescale 1ns / 1ps
module rod_raster (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  rod_pkg::t_cmd         i_cmd,
    input  rod_pkg::t_frame       i_frame,
    input  logic [rod_pkg::PIX_W-1:0] i_rdata,
    output rod_pkg::t_mem_req     o_mem,
    output rod_pkg::t_res         o_res,
    output logic                  o_busy,
    output logic                  o_done
);
    import rod_pkg::*;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    t_cmd r_cmd, n_cmd;
    t_res r_res, n_res;
    logic signed [CRD_W-1:0] r_c0, n_c0, r_c1, n_c1, r_r0, n_r0, r_r1, n_r1;
    logic signed [CRD_W-1:0] r_lo, n_lo, r_hi, n_hi, r_ca, n_ca, r_cb, n_cb;
    logic signed [CRD_W-1:0] r_row, n_row, r_col, n_col;

    logic signed [CRD_W-1:0] cols_s, rows_s, x_s, y_s, w_s, h_s;
    logic signed [CRD_W-1:0] row_sel, col_sel;
    logic edge_row, c0_in, c1_in, pix_in;

    function automatic logic in_range(logic signed [CRD_W-1:0] v,
                                      logic signed [CRD_W-1:0] lim);
        return (v >= CRD_ZERO) && (v < lim);
    endfunction

    assign cols_s   = ux8(i_frame.cols);
    assign rows_s   = ux8(i_frame.rows);
    assign x_s      = sx16(r_cmd.x_pos);
    assign y_s      = sx16(r_cmd.y_pos);
    assign w_s      = sx16(r_cmd.rect_w);
    assign h_s      = sx16(r_cmd.rect_h);
    assign edge_row = (r_row == r_r0) || (r_row == r_r1);
    assign c0_in    = in_range(r_c0, cols_s);
    assign c1_in    = in_range(r_c1, cols_s);
    assign pix_in   = in_range(x_s, cols_s) && in_range(y_s, rows_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_cmd <= n_cmd;
        r_res <= n_res;
        r_c0  <= n_c0;
        r_c1  <= n_c1;
        r_r0  <= n_r0;
        r_r1  <= n_r1;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_ca  <= n_ca;
        r_cb  <= n_cb;
        r_row <= n_row;
        r_col <= n_col;
    end

    // Next state and datapath registers.
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_cmd   = r_cmd;
        n_res   = r_res;
        n_c0    = r_c0;
        n_c1    = r_c1;
        n_r0    = r_r0;
        n_r1    = r_r1;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_ca    = r_ca;
        n_cb    = r_cb;
        n_row   = r_row;
        n_col   = r_col;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_cmd = i_cmd;
                    n_res = '0;
                    if (i_cmd.func == FUNC_DRAW) begin
                        n_state = ST_SETUP;
                    end else if (i_cmd.func == FUNC_READ || i_cmd.func == FUNC_WRITE) begin
                        n_state = ST_PIX;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SETUP: begin
                if (w_s > CRD_ZERO) begin
                    n_c0 = x_s;
                    n_c1 = x_s + w_s - CRD_ONE;
                end else begin
                    n_c0 = x_s + w_s + CRD_ONE;
                    n_c1 = x_s;
                end
                if (h_s > CRD_ZERO) begin
                    n_r0 = y_s;
                    n_r1 = y_s + h_s - CRD_ONE;
                end else begin
                    n_r0 = y_s + h_s + CRD_ONE;
                    n_r1 = y_s;
                end
                n_state = (w_s == CRD_ZERO || h_s == CRD_ZERO) ? ST_DONE : ST_CLIP;
            end
            ST_CLIP: begin
                n_lo    = (r_r0 < CRD_ZERO) ? CRD_ZERO : r_r0;
                n_hi    = (r_r1 > rows_s - CRD_ONE) ? rows_s - CRD_ONE : r_r1;
                n_ca    = (r_c0 < CRD_ZERO) ? CRD_ZERO : r_c0;
                n_cb    = (r_c1 > cols_s - CRD_ONE) ? cols_s - CRD_ONE : r_c1;
                n_row   = (r_r0 < CRD_ZERO) ? CRD_ZERO : r_r0;
                n_state = ST_ROW;
            end
            ST_ROW: begin
                if (r_row > r_hi) begin
                    n_state = ST_DONE;
                end else if (edge_row) begin
                    if (r_ca >= r_cb) begin
                        n_row = r_row + CRD_ONE;
                    end else begin
                        n_col   = r_ca + CRD_ONE;
                        n_state = ST_SPAN;
                    end
                end else begin
                    n_state = ST_RIGHT;
                end
            end
            ST_SPAN: begin
                if (r_col == r_cb) begin
                    n_row   = r_row + CRD_ONE;
                    n_state = ST_ROW;
                end else begin
                    n_col = r_col + CRD_ONE;
                end
            end
            ST_RIGHT: begin
                n_row   = r_row + CRD_ONE;
                n_state = ST_ROW;
            end
            ST_PIX: begin
                if (!pix_in) begin
                    n_res.outside_frame = 1'b1;
                    n_state = ST_DONE;
                end else if (r_cmd.func == FUNC_READ) begin
                    n_state = ST_RWAIT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RWAIT: begin
                n_res.read_value = i_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory requests; one multiplier forms row*cols+col for every access but the clear pass, which uses r_clr.
    always_comb begin
        o_mem       = '0;
        o_mem.wdata = r_cmd.pixel_color;
        row_sel     = r_row;
        col_sel     = r_col;
        case (r_state)
            ST_CLEAR: begin
                o_mem.we = 1'b1;
            end
            ST_ROW: begin
                if (r_row <= r_hi) begin
                    if (edge_row) begin
                        col_sel  = r_ca;
                        o_mem.we = (r_ca <= r_cb);
                    end else begin
                        col_sel  = r_c0;
                        o_mem.we = c0_in;
                    end
                end
            end
            ST_SPAN: begin
                o_mem.we = 1'b1;
            end
            ST_RIGHT: begin
                col_sel  = r_c1;
                o_mem.we = c1_in;
            end
            ST_PIX: begin
                row_sel  = y_s;
                col_sel  = x_s;
                o_mem.we = pix_in && (r_cmd.func == FUNC_WRITE);
                o_mem.re = pix_in && (r_cmd.func == FUNC_READ);
            end
            default: begin
                o_mem.we = 1'b0;
            end
        endcase
        if (r_state == ST_CLEAR) begin
            o_mem.addr  = r_clr;
            o_mem.wdata = '0;
        end else begin
            o_mem.addr = ADDR_W'(row_sel[ROW_IW-1:0]) * ADDR_W'(i_frame.cols)
                       + ADDR_W'(col_sel[COL_IW-1:0]);
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);
    assign o_res  = r_res;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

    // Spare function code: the block must answer it without touching the frame.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // Timeout: the clear pass plus about 1200 commands, each at most a full clipped
    // outline plus the longest gap, taken with plenty of margin.
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 115;

    // Frame geometry for each random phase: empty, single pixel, oversized and
    // full frames among them.
    int frame_plan_cols [RANDOM_PHASES] = '{128, 16, 0, 255, 1, 5, 129, 128, 200, 33};
    int frame_plan_rows [RANDOM_PHASES] = '{128, 8, 20, 255, 1, 128, 3, 0, 64, 17};

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    rod_pkg::t_cmd             i_cmd       = '0;
    logic                      o_done;
    rod_pkg::t_res             o_result;
    logic                      i_cfg_we    = 1'b0;
    logic                      i_cfg_idx   = rod_pkg::CFG_COLS;
    logic [rod_pkg::CFG_W-1:0] i_cfg_wdata = '0;

    rectangle_outline_drawer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Shadow of the framebuffer and of the frame-size registers.
    logic [rod_pkg::PIX_W-1:0] shadow_fb [rod_pkg::DEPTH];
    logic [rod_pkg::CFG_W-1:0] cols_cfg = rod_pkg::CFG_RESET;
    logic [rod_pkg::CFG_W-1:0] rows_cfg = rod_pkg::CFG_RESET;

    rod_pkg::t_cmd cmd_backlog [$];   // commands not yet presented to the block
    rod_pkg::t_res reply_q [$];       // predicted replies, oldest first

    int     error_count = 0;
    int     cycle_count = 0;
    int     gap_mode    = 1;          // 0: keep start asserted back to back
    int     mark_x      = 0;
    int     mark_y      = 0;
    bit     have_mark   = 1'b0;

    // ------------------------------------------------------------------
    // Frame model
    // ------------------------------------------------------------------

    // Register values above the store size act as the store size.
    function automatic longint used_cols();
        return (cols_cfg > rod_pkg::MAX_COLS) ? rod_pkg::MAX_COLS : longint'(cols_cfg);
    endfunction

    function automatic longint used_rows();
        return (rows_cfg > rod_pkg::MAX_ROWS) ? rod_pkg::MAX_ROWS : longint'(rows_cfg);
    endfunction

    function automatic bit in_frame(longint col, longint row);
        return col >= 0 && col < used_cols() && row >= 0 && row < used_rows();
    endfunction

    function automatic void plot(longint col, longint row, logic [7:0] color);
        if (in_frame(col, row))
            shadow_fb[row * used_cols() + col] = color;
    endfunction

    // Paint the outline only: full first and last rows, the left and right edge
    // pixels on the rows between them, everything outside the frame dropped.
    function automatic void paint_outline(rod_pkg::t_cmd cmd);
        longint c0, c1, r0, r1, lo, hi, a, b;
        if (cmd.rect_w == 0 || cmd.rect_h == 0)
            return;
        if (cmd.rect_w > 0) begin
            c0 = longint'(cmd.x_pos);
            c1 = longint'(cmd.x_pos) + longint'(cmd.rect_w) - 1;
        end else begin
            c0 = longint'(cmd.x_pos) + longint'(cmd.rect_w) + 1;
            c1 = longint'(cmd.x_pos);
        end
        if (cmd.rect_h > 0) begin
            r0 = longint'(cmd.y_pos);
            r1 = longint'(cmd.y_pos) + longint'(cmd.rect_h) - 1;
        end else begin
            r0 = longint'(cmd.y_pos) + longint'(cmd.rect_h) + 1;
            r1 = longint'(cmd.y_pos);
        end
        lo = (r0 < 0) ? 0 : r0;
        hi = (r1 > used_rows() - 1) ? used_rows() - 1 : r1;
        for (longint r = lo; r <= hi; r++) begin
            if (r == r0 || r == r1) begin
                a = (c0 < 0) ? 0 : c0;
                b = (c1 > used_cols() - 1) ? used_cols() - 1 : c1;
                for (longint c = a; c <= b; c++)
                    plot(c, r, cmd.pixel_color);
            end else begin
                plot(c0, r, cmd.pixel_color);
                plot(c1, r, cmd.pixel_color);
            end
        end
    endfunction

    // Advance the shadow frame by one command and return the reply it owes.
    function automatic rod_pkg::t_res apply_command(rod_pkg::t_cmd cmd);
        rod_pkg::t_res reply;
        longint        addr;
        reply = '0;
        if (cmd.func == rod_pkg::FUNC_DRAW) begin
            paint_outline(cmd);
        end else if (cmd.func == rod_pkg::FUNC_READ || cmd.func == rod_pkg::FUNC_WRITE) begin
            if (!in_frame(longint'(cmd.x_pos), longint'(cmd.y_pos))) begin
                reply.outside_frame = 1'b1;
            end else begin
                addr = longint'(cmd.y_pos) * used_cols() + longint'(cmd.x_pos);
                if (cmd.func == rod_pkg::FUNC_READ)
                    reply.read_value = shadow_fb[addr];
                else
                    shadow_fb[addr] = cmd.pixel_color;
            end
        end
        return reply;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void push_cmd(logic [1:0] func, int x, int y, int w, int h, int color);
        rod_pkg::t_cmd cmd;
        cmd.func        = func;
        cmd.x_pos       = 16'(x);
        cmd.y_pos       = 16'(y);
        cmd.rect_w      = 16'(w);
        cmd.rect_h      = 16'(h);
        cmd.pixel_color = 8'(color);
        cmd_backlog.push_back(cmd);
    endfunction

    // Mostly just around the frame, now and then anywhere in the 16-bit range.
    function automatic int near_coord(longint extent);
        if ($urandom_range(0, 99) < 12)
            return $urandom_range(0, 65535);
        return int'($urandom_range(0, int'(extent) + 7)) - 4;
    endfunction

    function automatic int pick_span(longint extent);
        int roll;
        int mag;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return 0;
        if (roll < 22)
            return $urandom_range(0, 65535);
        mag = $urandom_range(1, int'(extent) + 4);
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    // Reads often revisit the last written or drawn corner so they hit paint.
    function automatic rod_pkg::t_cmd make_cmd();
        rod_pkg::t_cmd cmd;
        int            roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            cmd.func = rod_pkg::FUNC_DRAW;
        else if (roll < 68)
            cmd.func = rod_pkg::FUNC_READ;
        else if (roll < 96)
            cmd.func = rod_pkg::FUNC_WRITE;
        else
            cmd.func = FUNC_SPARE;
        cmd.x_pos       = 16'(near_coord(used_cols()));
        cmd.y_pos       = 16'(near_coord(used_rows()));
        cmd.rect_w      = 16'(pick_span(used_cols()));
        cmd.rect_h      = 16'(pick_span(used_rows()));
        cmd.pixel_color = 8'($urandom_range(0, 255));
        if (cmd.func == rod_pkg::FUNC_READ && have_mark && $urandom_range(0, 9) < 4) begin
            cmd.x_pos = 16'(mark_x);
            cmd.y_pos = 16'(mark_y);
        end
        if (cmd.func == rod_pkg::FUNC_DRAW || cmd.func == rod_pkg::FUNC_WRITE) begin
            mark_x    = int'(cmd.x_pos);
            mark_y    = int'(cmd.y_pos);
            have_mark = 1'b1;
        end
        return cmd;
    endfunction

    // Mostly short pauses, a few long ones.
    function automatic int pick_gap();
        int roll;
        if (gap_mode == 0)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 80);
    endfunction

    // Sample on the falling edge, after every update of the rising edge.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (cmd_backlog.size() != 0 || start || busy || reply_q.size() != 0);
    endtask

    // Write both frame-size registers; the block is idle here.
    task automatic program_frame(int cols, int rows);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= rod_pkg::CFG_COLS;
        i_cfg_wdata <= cols[7:0];
        cols_cfg     = cols[7:0];
        @(posedge i_clk);
        i_cfg_idx   <= rod_pkg::CFG_ROWS;
        i_cfg_wdata <= rows[7:0];
        rows_cfg     = rows[7:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Command driver: present the next command, hold it while busy, log the
    // predicted reply on the accepting edge, then idle for the chosen gap.
    // ------------------------------------------------------------------
    int idle_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy)
                reply_q.push_back(apply_command(i_cmd));
            if (start && busy) begin
                // hold the beat until the block takes it
            end else if (idle_left > 0) begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (cmd_backlog.size() != 0) begin
                i_cmd     <= cmd_backlog.pop_front();
                start     <= 1'b1;
                idle_left <= pick_gap();
            end else begin
                start     <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Reply monitor: each o_done beat is checked against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        rod_pkg::t_res want;
        if (i_rst_n && o_done) begin
            if (reply_q.size() == 0) begin
                $display("%0t: unexpected beat: read_value %0d outside_frame %0d",
                         $time, o_result.read_value, o_result.outside_frame);
                error_count++;
            end else begin
                want = reply_q.pop_front();
                if (o_result.read_value !== want.read_value) begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.read_value, o_result.read_value);
                    error_count++;
                end
                if (o_result.outside_frame !== want.outside_frame) begin
                    $display("%0t: outside_frame expected %0d actual %0d",
                             $time, want.outside_frame, o_result.outside_frame);
                    error_count++;
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed commands on the reset geometry, then random
    // phases on several frame geometries.
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < rod_pkg::DEPTH; i++)
            shadow_fb[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Let the clear pass run out before anything else.
        repeat (2) @(posedge i_clk);
        wait_idle();

        // Two frame corners, pixels just outside the left, right and bottom edges, and a 16-bit extreme.
        push_cmd(rod_pkg::FUNC_READ,  0, 0, 0, 0, 0);
        push_cmd(rod_pkg::FUNC_WRITE, 0, 0, 0, 0, 8'hFF);
        push_cmd(rod_pkg::FUNC_READ,  0, 0, 0, 0, 0);
        push_cmd(rod_pkg::FUNC_WRITE, 127, 127, 0, 0, 8'h55);
        push_cmd(rod_pkg::FUNC_READ,  127, 127, 0, 0, 0);
        push_cmd(rod_pkg::FUNC_WRITE, 128, 5, 0, 0, 8'hAA);
        push_cmd(rod_pkg::FUNC_READ,  -1, 0, 0, 0, 0);
        push_cmd(rod_pkg::FUNC_READ,  0, 128, 0, 0, 0);
        push_cmd(rod_pkg::FUNC_WRITE, 5, -32768, 0, 0, 8'hAA);
        // Zero width or height draws nothing.
        push_cmd(rod_pkg::FUNC_DRAW,  10, 10, 0, 5, 8'h77);
        push_cmd(rod_pkg::FUNC_DRAW,  10, 10, 5, 0, 8'h77);
        push_cmd(rod_pkg::FUNC_READ,  10, 10, 0, 0, 0);
        // Small box: edge painted, interior left alone.
        push_cmd(rod_pkg::FUNC_DRAW,  2, 3, 4, 3, 8'h11);
        push_cmd(rod_pkg::FUNC_READ,  3, 4, 0, 0, 0);
        push_cmd(rod_pkg::FUNC_READ,  5, 4, 0, 0, 0);
        // Negative spans extend left and up from the anchor.
        push_cmd(rod_pkg::FUNC_DRAW,  20, 20, -4, -3, 8'h22);
        push_cmd(rod_pkg::FUNC_READ,  17, 18, 0, 0, 0);
        push_cmd(rod_pkg::FUNC_READ,  18, 19, 0, 0, 0);
        // Whole-frame outline, then boxes clipped down from the widest spans.
        push_cmd(rod_pkg::FUNC_DRAW,  0, 0, 128, 128, 8'h33);
        push_cmd(rod_pkg::FUNC_DRAW,  32767, 32767, -32768, -32768, 8'h44);
        push_cmd(rod_pkg::FUNC_DRAW,  -32768, -32768, 32767, 32767, 8'h66);
        push_cmd(rod_pkg::FUNC_READ,  0, 127, 0, 0, 0);
        push_cmd(rod_pkg::FUNC_READ,  127, 0, 0, 0, 0);
        // Spare function code with every field busy.
        push_cmd(FUNC_SPARE, 32767, -1, 16'h5555, 16'hAAAA, 8'hF0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            program_frame(frame_plan_cols[p], frame_plan_rows[p]);
            gap_mode  = (p % 4 == 2) ? 0 : 1;
            have_mark = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                cmd_backlog.push_back(make_cmd());
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (error_count == 0 && reply_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
